[hdl/tpsc_pkg.sv]
// types, constants and result codes for the tcp packet statistics counter
`timescale 1ns / 1ps

package tpsc_pkg;

	// frame length limit; the byte position saturates here
	localparam int unsigned MAX_FRAME_BYTES = 16384;
	localparam int unsigned POS_W           = 15;

	// byte offsets of the captured header fields, from the start of the ethernet header
	localparam logic [POS_W-1:0] POS_IHL       = POS_W'(14);
	localparam logic [POS_W-1:0] POS_TOTLEN_HI = POS_W'(16);
	localparam logic [POS_W-1:0] POS_TOTLEN_LO = POS_W'(17);
	localparam logic [POS_W-1:0] POS_PROTOCOL  = POS_W'(23);
	localparam logic [POS_W-1:0] POS_DOFF      = POS_W'(46);
	localparam logic [POS_W-1:0] POS_FLAGS     = POS_W'(47);
	localparam logic [POS_W-1:0] MAX_POS       = POS_W'(MAX_FRAME_BYTES);

	// length thresholds
	localparam logic [POS_W-1:0] MIN_IP_LEN  = POS_W'(34);
	localparam logic [POS_W-1:0] MIN_TCP_LEN = POS_W'(54);

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam int unsigned SYN_BIT = 1;
	localparam int unsigned ACK_BIT = 4;

	// per-frame result codes
	typedef enum logic [2:0] {
		ST_SHORT       = 3'd0,
		ST_NOT_TCP     = 3'd1,
		ST_NO_TCP_HDR  = 3'd2,
		ST_BAD_PAYLOAD = 3'd3,
		ST_COUNTED     = 3'd4
	} frame_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [63:0] packets_total;
		logic [63:0] bytes_total;
		logic [63:0] synack_total;
		logic [63:0] payload_total;
		logic [2:0]  frame_status;
		logic        synack_seen;
	} out_item_t;

endpackage

[hdl/tcp_packet_stats_counter_top.sv]
// top level: per-byte header capture and per-frame tcp statistics counters
`timescale 1ns / 1ps

// Takes an Ethernet/IPv4 frame one byte per item (last_byte marks the end) and
// gives one result item per frame with the running frame, byte, SYN+ACK and TCP
// payload totals plus the status of that frame. One byte is taken every cycle
// unless the input stalls: a byte waits in the input register, where the header
// capture and, on the last byte, the counter update are worked out, so a result
// is written to the output register as its last byte leaves the input register.
// The only stall is a last byte that finds the previous result still untaken in
// the output register; input ready drops then until that result is taken.
module tcp_packet_stats_counter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tpsc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tpsc_pkg::out_item_t out_data
);
	import tpsc_pkg::*;

	logic             valid_s1;
	in_item_t         data_s1;
	logic             adv_s1;

	logic [POS_W-1:0] byte_position_q;
	logic [7:0]       protocol_q;
	logic [15:0]      total_length_q;
	logic [3:0]       ip_words_q;
	logic [3:0]       tcp_words_q;
	logic [7:0]       flags_q;

	logic [63:0]      packet_count_q;
	logic [63:0]      byte_count_q;
	logic [63:0]      synack_count_q;
	logic [63:0]      payload_count_q;
	frame_status_t    status_q;
	logic             seen_q;
	logic             out_valid_q;

	logic [POS_W-1:0] pos_next;
	logic [7:0]       protocol_next;
	logic [15:0]      total_length_next;
	logic [3:0]       ip_words_next;
	logic [3:0]       tcp_words_next;
	logic [7:0]       flags_next;

	logic [16:0]      payload_wide;
	logic [POS_W-1:0] room;
	logic             payload_ok;
	logic             synack;
	frame_status_t    status_next;

	// the byte in s1 moves on unless it ends a frame while a result is still waiting
	assign adv_s1   = valid_s1 && (!data_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// header capture by byte position, position saturates at the frame limit
	always_comb begin
		pos_next          = byte_position_q;
		protocol_next     = protocol_q;
		total_length_next = total_length_q;
		ip_words_next     = ip_words_q;
		tcp_words_next    = tcp_words_q;
		flags_next        = flags_q;
		if (byte_position_q < MAX_POS) begin
			case (byte_position_q)
				POS_IHL:       ip_words_next = data_s1.data_byte[3:0];
				POS_TOTLEN_HI: total_length_next[15:8] = data_s1.data_byte;
				POS_TOTLEN_LO: total_length_next[7:0] = data_s1.data_byte;
				POS_PROTOCOL:  protocol_next = data_s1.data_byte;
				POS_DOFF:      tcp_words_next = data_s1.data_byte[7:4];
				POS_FLAGS:     flags_next = data_s1.data_byte;
				default:       ;
			endcase
			pos_next = byte_position_q + POS_W'(1);
		end
	end

	// frame classification; every field it needs was captured before the last byte
	always_comb begin
		payload_wide = {1'b0, total_length_q} - {11'd0, ip_words_q, 2'b00}
			- {11'd0, tcp_words_q, 2'b00};
		room         = pos_next - MIN_TCP_LEN;
		payload_ok   = !payload_wide[16] && (payload_wide[15:0] <= {1'b0, room});
		synack       = flags_q[ACK_BIT] && flags_q[SYN_BIT];
		if (pos_next < MIN_IP_LEN) begin
			status_next = ST_SHORT;
		end else if (protocol_q != PROTO_TCP) begin
			status_next = ST_NOT_TCP;
		end else if (pos_next < MIN_TCP_LEN) begin
			status_next = ST_NO_TCP_HDR;
		end else if (!payload_ok) begin
			status_next = ST_BAD_PAYLOAD;
		end else begin
			status_next = ST_COUNTED;
		end
	end

	// per-frame state, cleared at every frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			protocol_q      <= '0;
			total_length_q  <= '0;
			ip_words_q      <= '0;
			tcp_words_q     <= '0;
			flags_q         <= '0;
		end else if (adv_s1) begin
			if (data_s1.last_byte) begin
				byte_position_q <= '0;
				protocol_q      <= '0;
				total_length_q  <= '0;
				ip_words_q      <= '0;
				tcp_words_q     <= '0;
				flags_q         <= '0;
			end else begin
				byte_position_q <= pos_next;
				protocol_q      <= protocol_next;
				total_length_q  <= total_length_next;
				ip_words_q      <= ip_words_next;
				tcp_words_q     <= tcp_words_next;
				flags_q         <= flags_next;
			end
		end
	end

	// running totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_count_q  <= '0;
			byte_count_q    <= '0;
			synack_count_q  <= '0;
			payload_count_q <= '0;
			status_q        <= ST_SHORT;
			seen_q          <= 1'b0;
			out_valid_q     <= 1'b0;
		end else if (adv_s1 && data_s1.last_byte) begin
			packet_count_q <= packet_count_q + 64'd1;
			byte_count_q   <= byte_count_q + {49'd0, pos_next};
			status_q       <= status_next;
			seen_q         <= (status_next == ST_COUNTED) && synack;
			out_valid_q    <= 1'b1;
			if (status_next == ST_COUNTED) begin
				payload_count_q <= payload_count_q + {48'd0, payload_wide[15:0]};
				if (synack) begin
					synack_count_q <= synack_count_q + 64'd1;
				end
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// totals stay put while a result waits, so they drive the result directly
	assign out_valid              = out_valid_q;
	assign out_data.packets_total = packet_count_q;
	assign out_data.bytes_total   = byte_count_q;
	assign out_data.synack_total  = synack_count_q;
	assign out_data.payload_total = payload_count_q;
	assign out_data.frame_status  = status_q;
	assign out_data.synack_seen   = seen_q;

endmodule

[hdl/tpsc_checker.sv]
// port-level checker for the tcp packet statistics counter, bound to the top level
`timescale 1ns / 1ps

module tpsc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input tpsc_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input tpsc_pkg::out_item_t out_data
);
	import tpsc_pkg::*;

	// an offered item holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("offered item changed while stalled");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// input stalls only behind an untaken result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// a synack is only counted on a counted frame
	a_synack_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.synack_seen |-> out_data.frame_status == ST_COUNTED)
		else $error("synack seen on a frame that was not counted");

	// each new result counts exactly one more frame
	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid |->
		out_data.packets_total == $past(out_data.packets_total) + 64'd1)
		else $error("frame count did not step by one");

endmodule

bind tcp_packet_stats_counter_top tpsc_checker u_tpsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
